// File: src/lbp_riu2_contrast_assert.svh
// ----------------------------------------------------------------------------
// LBP riu2 contrast assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LBP_RIU2_CONTRAST_ASSERT_SVH
`define LBP_RIU2_CONTRAST_ASSERT_SVH

// same-cycle implication
`define LBPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbpc check failed");

// next-cycle implication
`define LBPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbpc check failed");

`endif

// File: src/lbpc_pkg.sv
// ----------------------------------------------------------------------------
// LBP riu2 contrast package
// Build constants, register indexes and bilinear tap tables.
// ----------------------------------------------------------------------------
package lbpc_pkg;

  localparam int LINE_LENGTH_DEF = 1024;
  localparam int NEIGHBORS       = 8;
  localparam int RADIUS          = 1;
  localparam int MARGIN          = RADIUS + 1;
  localparam int FRACTION_BITS   = 8;
  localparam int UNIFORM_MAX     = 2;
  localparam int CODE_NONUNIFORM = NEIGHBORS + 1;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [10:0] HEIGHT_RST = 11'd480;
  localparam logic [21:0] CONTRAST_MAX = 22'h3FFFFF;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  // window taps per neighbor, window indexed [y][x]
  localparam logic [1:0] TAP_X0 [NEIGHBORS] = '{2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd1};
  localparam logic [1:0] TAP_X1 [NEIGHBORS] = '{2'd2, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2};
  localparam logic [1:0] TAP_Y0 [NEIGHBORS] = '{2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1};
  localparam logic [1:0] TAP_Y1 [NEIGHBORS] = '{2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2};

  // bilinear weights, Q.16, sum to 65536
  localparam logic [16:0] TAP_W00 [NEIGHBORS] =
    '{17'd65536, 17'd13575, 17'd65536, 17'd32761, 17'd65536, 17'd13575, 17'd65536, 17'd5625};
  localparam logic [16:0] TAP_W01 [NEIGHBORS] =
    '{17'd0, 17'd5625, 17'd0, 17'd13575, 17'd0, 17'd32761, 17'd0, 17'd13575};
  localparam logic [16:0] TAP_W10 [NEIGHBORS] =
    '{17'd0, 17'd32761, 17'd0, 17'd13575, 17'd0, 17'd5625, 17'd0, 17'd13575};
  localparam logic [16:0] TAP_W11 [NEIGHBORS] =
    '{17'd0, 17'd13575, 17'd0, 17'd5625, 17'd0, 17'd13575, 17'd0, 17'd32761};

endpackage

// File: src/lbp_riu2_contrast.sv
// ----------------------------------------------------------------------------
// LBP riu2 contrast
// Rotation-invariant uniform LBP code (8 neighbors, radius 1) and neighbor
// variance over a raster-order 8-bit pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock while out_ready stays high; a result beat
// that waits holds the whole pipeline and drops in_ready. Two line memories,
// read once per pixel at the current column, feed a 3x3 window; the pixel
// completing the window passes registers s1 to s5, then out_valid rises.
// One result per pixel at least two pixels from every edge, none for the
// border. Contrast is unsigned Q.8, saturated. Change image_width and
// image_height only while idle.
module lbp_riu2_contrast #(
  parameter int LINE_LENGTH = lbpc_pkg::LINE_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_col,
  output logic [9:0]  out_row,
  output logic [3:0]  out_lbp_code,
  output logic [21:0] out_contrast
);

  localparam int CW = $clog2(LINE_LENGTH);
  localparam int EW = 13;
  localparam int NB = lbpc_pkg::NEIGHBORS;

  logic [10:0] width_r, height_r;
  logic [EW-1:0] w_eff, h_eff;
  logic adv, acc_in;

  logic [CW-1:0] col_cnt_r, col_cnt_nxt, c_cur;
  logic [10:0]   row_cnt_r, row_cnt_nxt, r_cur;
  logic          emit0;

  logic [7:0] line0_mem [LINE_LENGTH];
  logic [7:0] line1_mem [LINE_LENGTH];
  logic [7:0] rd0_r, rd1_r;

  logic          s1_valid_r, s1_emit_r, s1_par_r;
  logic [7:0]    s1_px_r;
  logic [CW-1:0] s1_col_r;
  logic [10:0]   s1_row_r;

  logic [7:0] win_r [3][3];

  logic       s2_valid_r;
  logic [9:0] s2_col_r, s2_row_r;
  logic [15:0] samp [NB];

  logic        s3_valid_r;
  logic [9:0]  s3_col_r, s3_row_r;
  logic [15:0] v_r [NB];
  logic [7:0]  s3_ctr_r;
  logic [NB-1:0] bits;
  logic [3:0]  ones, trans, code;
  logic [18:0] s1sum;

  logic        s4_valid_r;
  logic [9:0]  s4_col_r, s4_row_r;
  logic [3:0]  s4_code_r;
  logic [31:0] sq_r [NB];
  logic [18:0] s1sum_r;
  logic [34:0] s2sum;

  logic        s5_valid_r;
  logic [9:0]  s5_col_r, s5_row_r;
  logic [3:0]  s5_code_r;
  logic [34:0] s2sum_r;
  logic [37:0] s1sq_r;
  logic [37:0] num;
  logic [24:0] con;

  logic        out_valid_r;
  logic [9:0]  out_col_r, out_row_r;
  logic [3:0]  out_code_r;
  logic [21:0] out_con_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lbpc_pkg::WIDTH_RST;
      height_r <= lbpc_pkg::HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lbpc_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        lbpc_pkg::REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = EW'(width_r);
    if (w_eff == '0) w_eff = EW'(1);
    else if (w_eff > EW'(LINE_LENGTH)) w_eff = EW'(LINE_LENGTH);
    h_eff = EW'(height_r);
    if (h_eff == '0) h_eff = EW'(1);
  end

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign acc_in   = in_valid && adv;

  always_comb begin
    c_cur = in_frame_start ? '0 : col_cnt_r;
    r_cur = in_frame_start ? '0 : row_cnt_r;
    emit0 = (EW'(c_cur) >= EW'(lbpc_pkg::RADIUS + lbpc_pkg::MARGIN))
         && (EW'(c_cur) + EW'(lbpc_pkg::MARGIN - lbpc_pkg::RADIUS) < w_eff)
         && (EW'(r_cur) >= EW'(lbpc_pkg::RADIUS + lbpc_pkg::MARGIN))
         && (EW'(r_cur) + EW'(lbpc_pkg::MARGIN - lbpc_pkg::RADIUS) < h_eff);
    col_cnt_nxt = c_cur + CW'(1);
    row_cnt_nxt = r_cur;
    if (EW'(c_cur) + EW'(1) >= w_eff) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (EW'(r_cur) + EW'(1) >= h_eff) ? '0 : r_cur + 11'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (acc_in) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // read-first: the line below sees the old entry
  always_ff @(posedge clk) begin
    if (acc_in) begin
      rd0_r <= line0_mem[c_cur];
      rd1_r <= line1_mem[c_cur];
      if (!r_cur[0]) begin
        line0_mem[c_cur] <= in_pixel;
      end else begin
        line1_mem[c_cur] <= in_pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r && s1_emit_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      out_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      s1_emit_r <= emit0;
      s1_par_r  <= r_cur[0];
      s1_px_r   <= in_pixel;
      s1_col_r  <= c_cur;
      s1_row_r  <= r_cur;
    end
  end

  // window shift; top row is the older stored line
  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      for (int y = 0; y < 3; y++) begin
        win_r[y][0] <= win_r[y][1];
        win_r[y][1] <= win_r[y][2];
      end
      win_r[0][2] <= s1_par_r ? rd1_r : rd0_r;
      win_r[1][2] <= s1_par_r ? rd0_r : rd1_r;
      win_r[2][2] <= s1_px_r;
      s2_col_r <= 10'(EW'(s1_col_r) - EW'(lbpc_pkg::RADIUS));
      s2_row_r <= 10'(s1_row_r - 11'(lbpc_pkg::RADIUS));
    end
  end

  always_comb begin
    logic [24:0] acc;
    for (int n = 0; n < NB; n++) begin
      acc = 25'(win_r[lbpc_pkg::TAP_Y0[n]][lbpc_pkg::TAP_X0[n]]) * 25'(lbpc_pkg::TAP_W00[n])
          + 25'(win_r[lbpc_pkg::TAP_Y0[n]][lbpc_pkg::TAP_X1[n]]) * 25'(lbpc_pkg::TAP_W01[n])
          + 25'(win_r[lbpc_pkg::TAP_Y1[n]][lbpc_pkg::TAP_X0[n]]) * 25'(lbpc_pkg::TAP_W10[n])
          + 25'(win_r[lbpc_pkg::TAP_Y1[n]][lbpc_pkg::TAP_X1[n]]) * 25'(lbpc_pkg::TAP_W11[n]);
      samp[n] = 16'((acc + 25'(1 << (lbpc_pkg::FRACTION_BITS - 1))) >> lbpc_pkg::FRACTION_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      for (int n = 0; n < NB; n++) v_r[n] <= samp[n];
      s3_ctr_r <= win_r[1][1];
      s3_col_r <= s2_col_r;
      s3_row_r <= s2_row_r;
    end
  end

  always_comb begin
    ones  = '0;
    trans = '0;
    s1sum = '0;
    for (int n = 0; n < NB; n++) begin
      bits[n] = v_r[n] > {s3_ctr_r, 8'd0};
      ones    = ones + 4'(bits[n]);
      s1sum   = s1sum + 19'(v_r[n]);
    end
    for (int n = 0; n < NB; n++) begin
      trans = trans + 4'(bits[n] != bits[(n + NB - 1) % NB]);
    end
    code = (trans > 4'(lbpc_pkg::UNIFORM_MAX)) ? 4'(lbpc_pkg::CODE_NONUNIFORM) : ones;
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid_r) begin
      for (int n = 0; n < NB; n++) sq_r[n] <= 32'(v_r[n]) * 32'(v_r[n]);
      s1sum_r   <= s1sum;
      s4_code_r <= code;
      s4_col_r  <= s3_col_r;
      s4_row_r  <= s3_row_r;
    end
  end

  always_comb begin
    s2sum = '0;
    for (int n = 0; n < NB; n++) s2sum = s2sum + 35'(sq_r[n]);
  end

  always_ff @(posedge clk) begin
    if (adv && s4_valid_r) begin
      s2sum_r   <= s2sum;
      s1sq_r    <= 38'(s1sum_r) * 38'(s1sum_r);
      s5_code_r <= s4_code_r;
      s5_col_r  <= s4_col_r;
      s5_row_r  <= s4_row_r;
    end
  end

  // den = P*P << F = 2^14
  always_comb begin
    num = (38'(s2sum_r) << 3) - s1sq_r;
    con = 25'((num + 38'(8192)) >> 14);
  end

  always_ff @(posedge clk) begin
    if (adv && s5_valid_r) begin
      out_col_r  <= s5_col_r;
      out_row_r  <= s5_row_r;
      out_code_r <= s5_code_r;
      out_con_r  <= (con > 25'(lbpc_pkg::CONTRAST_MAX)) ? lbpc_pkg::CONTRAST_MAX : con[21:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_col      = out_col_r;
  assign out_row      = out_row_r;
  assign out_lbp_code = out_code_r;
  assign out_contrast = out_con_r;

`include "lbp_riu2_contrast_assert.svh"

  `LBPC_ASSERT_NOW(a_code_range, out_valid_r, out_code_r <= 4'(lbpc_pkg::CODE_NONUNIFORM))
  `LBPC_ASSERT_NOW(a_col_interior, out_valid_r, out_col_r >= 10'(lbpc_pkg::MARGIN))
  `LBPC_ASSERT_NEXT(a_frame_restart, acc_in && in_frame_start && w_eff > EW'(1), col_cnt_r == CW'(1) && row_cnt_r == '0)
  `LBPC_ASSERT_NEXT(a_stall_holds_pipe, s5_valid_r && !adv, s5_valid_r)

endmodule

// File: dv/tb_lbp_riu2_contrast.sv
// ----------------------------------------------------------------------------
// LBP riu2 contrast testbench
// Streams pixel frames of various sizes and textures through the block.
// An internal predictor models the line stores and the 3x3 window, then
// computes the riu2 code and the neighbor variance. Each output beat is
// checked field by field, in order, against the predicted results.
// ----------------------------------------------------------------------------
module tb_lbp_riu2_contrast;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LINE_LEN    = lbpc_pkg::LINE_LENGTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef enum int {PAT_NOISE, PAT_BINARY, PAT_SMOOTH, PAT_FLAT, PAT_SPOT} texture_e;

  typedef struct {
    logic [9:0]  col;
    logic [9:0]  row;
    logic [3:0]  code;
    logic [21:0] contrast;
  } lbp_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [0:0]  cfg_index;
  logic [10:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_pixel;
  logic        in_frame_start;
  logic        out_valid;
  logic        out_ready;
  logic [9:0]  out_col;
  logic [9:0]  out_row;
  logic [3:0]  out_lbp_code;
  logic [21:0] out_contrast;

  lbp_riu2_contrast i_dut (.*);

  lbp_result_t expected_q[$];
  int unsigned fails;
  int unsigned cycles;
  int unsigned items_sent;
  bit          no_idle;
  int unsigned holds_asked;
  int unsigned holds_done;

  // predictor state
  logic [7:0]  line_mem [2*LINE_LEN];
  logic [7:0]  win [3][3];
  int unsigned col_cnt, row_cnt;
  logic [10:0] geom_w, geom_h;

  initial begin
    clk = 1'b0;
    forever #4ns clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_lbp_riu2_contrast NOT OK");
      $finish;
    end
  end

  // receiver: random ready with bursts of stall, one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      if (holds_done != holds_asked) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        holds_done++;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // result checker, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk) begin
    lbp_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat col=%0d row=%0d", out_col, out_row);
        fails++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_col !== exp_r.col) begin
          $error("col: expected %0d actual %0d", exp_r.col, out_col);
          fails++;
        end
        if (out_row !== exp_r.row) begin
          $error("row: expected %0d actual %0d", exp_r.row, out_row);
          fails++;
        end
        if (out_lbp_code !== exp_r.code) begin
          $error("lbp_code: expected %0d actual %0d", exp_r.code, out_lbp_code);
          fails++;
        end
        if (out_contrast !== exp_r.contrast) begin
          $error("contrast: expected %0d actual %0d", exp_r.contrast, out_contrast);
          fails++;
        end
      end
    end
  end

  function automatic void predict_pixel(logic [7:0] px, logic fs);
    int unsigned w, h, c, r;
    bit emit;
    longint unsigned acc, v, centre, s1, s2, num, con;
    bit above [lbpc_pkg::NEIGHBORS];
    int unsigned ones, trans;
    lbp_result_t res;
    w = geom_w;
    h = geom_h;
    if (w == 0) w = 1;
    if (w > LINE_LEN) w = LINE_LEN;
    if (h == 0) h = 1;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    c = col_cnt % LINE_LEN;
    r = row_cnt;
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 2; x++) win[y][x] = win[y][x+1];
    win[0][2] = line_mem[(r % 2) * LINE_LEN + c];
    win[1][2] = line_mem[((r + 1) % 2) * LINE_LEN + c];
    win[2][2] = px;
    line_mem[(r % 2) * LINE_LEN + c] = px;
    emit = c >= 3 && c + 1 < w && r >= 3 && r + 1 < h;
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
    if (!emit) return;
    centre = longint'(win[1][1]) << lbpc_pkg::FRACTION_BITS;
    s1 = 0;
    s2 = 0;
    ones = 0;
    trans = 0;
    for (int n = 0; n < lbpc_pkg::NEIGHBORS; n++) begin
      acc = longint'(win[lbpc_pkg::TAP_Y0[n]][lbpc_pkg::TAP_X0[n]]) * lbpc_pkg::TAP_W00[n]
          + longint'(win[lbpc_pkg::TAP_Y0[n]][lbpc_pkg::TAP_X1[n]]) * lbpc_pkg::TAP_W01[n]
          + longint'(win[lbpc_pkg::TAP_Y1[n]][lbpc_pkg::TAP_X0[n]]) * lbpc_pkg::TAP_W10[n]
          + longint'(win[lbpc_pkg::TAP_Y1[n]][lbpc_pkg::TAP_X1[n]]) * lbpc_pkg::TAP_W11[n];
      v = (acc + 128) >> lbpc_pkg::FRACTION_BITS;
      above[n] = v > centre;
      ones += above[n];
      s1 += v;
      s2 += v * v;
    end
    for (int n = 0; n < lbpc_pkg::NEIGHBORS; n++)
      if (above[n] != above[(n + lbpc_pkg::NEIGHBORS - 1) % lbpc_pkg::NEIGHBORS]) trans++;
    num = lbpc_pkg::NEIGHBORS * s2 - s1 * s1;
    con = (num + 8192) / 16384;
    if (con > lbpc_pkg::CONTRAST_MAX) con = lbpc_pkg::CONTRAST_MAX;
    res.col      = 10'(c - 1);
    res.row      = 10'(r - 1);
    res.code     = 4'(trans > lbpc_pkg::UNIFORM_MAX ? lbpc_pkg::CODE_NONUNIFORM : ones);
    res.contrast = 22'(con);
    expected_q.push_back(res);
  endfunction

  task automatic send_pixel(logic [7:0] px, logic fs);
    int gap;
    gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel       <= px;
    in_frame_start <= fs;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_pixel(px, fs);
    items_sent++;
  endtask

  function automatic logic [7:0] texel(texture_e t, int x, int y, logic [7:0] base);
    case (t)
      PAT_BINARY: begin
        return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      PAT_SMOOTH: begin
        return 8'(base + x * 3 + y * 2 + $urandom_range(0, 2));
      end
      PAT_FLAT: begin
        return base;
      end
      PAT_SPOT: begin
        return ($urandom_range(0, 7) == 0) ? 8'(~base) : base;
      end
      default: begin
        return 8'($urandom);
      end
    endcase
  endfunction

  // count below w*h truncates the frame
  task automatic send_frame(int w, int h, texture_e t, int count = -1);
    logic [7:0] base;
    int total;
    base = 8'($urandom);
    total = (count < 0) ? w * h : count;
    for (int i = 0; i < total; i++)
      send_pixel(texel(t, i % w, i / w, base), i == 0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_geometry(logic [10:0] w, logic [10:0] h);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= lbpc_pkg::REG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= lbpc_pkg::REG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    geom_w = w;
    geom_h = h;
  endtask

  task automatic test_directed();
    set_geometry(11'd5, 11'd5);
    // dark center among bright neighbors, then bright center in dark field
    for (int i = 0; i < 25; i++) send_pixel((i == 12) ? 8'd0 : 8'd255, i == 0);
    for (int i = 0; i < 25; i++) send_pixel((i == 12) ? 8'd255 : 8'd0, i == 0);
    send_frame(5, 5, PAT_BINARY);
  endtask

  task automatic test_random();
    int w, h;
    int unsigned stop_at;
    stop_at = items_sent + 120;
    while (items_sent < stop_at) begin
      w = $urandom_range(5, 12);
      h = $urandom_range(5, 10);
      set_geometry(11'(w), 11'(h));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 7) == 0)
          send_frame(w, h, texture_e'($urandom_range(0, 4)), $urandom_range(1, w * h - 1));
        else
          send_frame(w, h, texture_e'($urandom_range(0, 4)));
      end
    end
  endtask

  task automatic test_backpressure();
    set_geometry(11'd12, 11'd12);
    holds_asked++;
    send_frame(12, 12, PAT_NOISE);
  endtask

  task automatic test_drain_pause();
    set_geometry(11'd10, 11'd10);
    for (int i = 0; i < 100; i++) begin
      if (i == 55) wait_idle();
      send_pixel(8'($urandom), i == 0);
    end
  endtask

  task automatic test_geometry_limits();
    set_geometry(11'd0, 11'd5);
    send_frame(1, 5, PAT_NOISE);
    set_geometry(11'd5, 11'd0);
    send_frame(5, 2, PAT_NOISE);
    set_geometry(11'd2047, 11'd5);
    send_frame(LINE_LEN, 5, PAT_NOISE, 40);
    set_geometry(11'd5, 11'd2047);
    send_frame(5, 2047, PAT_NOISE, 60);
  endtask

  task automatic test_full_rate();
    set_geometry(11'd9, 11'd8);
    no_idle = 1'b1;
    repeat (2) send_frame(9, 8, texture_e'($urandom_range(0, 4)));
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= lbpc_pkg::REG_WIDTH;
    cfg_wdata      <= '0;
    in_valid       <= 1'b0;
    in_pixel       <= '0;
    in_frame_start <= 1'b0;
    items_sent = 0;
    no_idle = 1'b0;
    col_cnt = 0;
    row_cnt = 0;
    geom_w = lbpc_pkg::WIDTH_RST;
    geom_h = lbpc_pkg::HEIGHT_RST;
    for (int i = 0; i < 2 * LINE_LEN; i++) line_mem[i] = '0;
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++) win[y][x] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random();
    test_backpressure();
    test_drain_pause();
    test_geometry_limits();
    test_full_rate();

    wait_idle();
    if (fails == 0) begin
      $display("tb_lbp_riu2_contrast OK");
    end else begin
      $display("tb_lbp_riu2_contrast NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/lbpc_pkg.sv
src/lbp_riu2_contrast.sv
dv/tb_lbp_riu2_contrast.sv
